// ----- hdl/ssdff_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame formatter package
// Transaction types, function codes, segment codes and conversion helpers.
// ----------------------------------------------------------------------------
package ssdff_pkg;

	localparam logic [1:0] FUNC_DEC8 = 2'd0;
	localparam logic [1:0] FUNC_DEC4 = 2'd1;
	localparam logic [1:0] FUNC_DUTY = 2'd2;
	localparam logic [1:0] FUNC_DASH = 2'd3;

	localparam logic [7:0] CODE_D    = 8'h3D;
	localparam logic [7:0] CODE_DASH = 8'h01;
	localparam logic [7:0] CODE_OVF  = 8'h40;
	localparam logic [7:0] CODE_OFF  = 8'h00;

	localparam logic [31:0] LIMIT_DEC8 = 32'd99999999;
	localparam logic [31:0] LIMIT_DEC4 = 32'd9999;
	localparam logic [31:0] LIMIT_DUTY = 32'd100;

	localparam int BIN_W   = 27;
	localparam int BCD_W   = 32;
	localparam int DD_W    = BCD_W + BIN_W;
	localparam int STEPS_A = 7;
	localparam int STEPS_B = 6;

	localparam logic [2:0] POS_DEC8 = 3'd7;
	localparam logic [2:0] POS_HALF = 3'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic        chip_index;
		logic        half;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic [3:0] lead_addr;
		logic [7:0] lead_data;
		logic [3:0] trail_addr;
		logic [7:0] trail_data;
		logic       last;
	} frame_t;

	typedef struct packed {
		logic [1:0]      func;
		logic            chip_index;
		logic            half;
		logic            ovf;
		logic [DD_W-1:0] dd;
	} conv_t;

	function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] x);
		logic [DD_W-1:0] y;
		y = x;
		for (int i = 0; i < BCD_W / 4; i++) begin
			if (y[BIN_W + 4*i +: 4] >= 4'd5) begin
				y[BIN_W + 4*i +: 4] = y[BIN_W + 4*i +: 4] + 4'd3;
			end
		end
		return {y[DD_W-2:0], 1'b0};
	endfunction

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'h7e;
			4'd1: s = 8'h30;
			4'd2: s = 8'h6d;
			4'd3: s = 8'h79;
			4'd4: s = 8'h33;
			4'd5: s = 8'h5b;
			4'd6: s = 8'h5f;
			4'd7: s = 8'h70;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h7b;
			default: s = CODE_OFF;
		endcase
		return s;
	endfunction

endpackage

// ----- hdl/seven_segment_decimal_frame_formatter.sv -----
// ----------------------------------------------------------------------------
// Seven-segment decimal frame formatter
// Turns a display request into one two-chip daisy-chain frame per digit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It yields eight frames
// (eight-digit mode) or four (other modes), one frame per cycle on consecutive
// cycles, each marked by strobe for one cycle and the final one flagged last;
// the receiver cannot stall, so it must take every strobed frame. A request
// passes the pipeline stages, the serialiser registers and the frame output
// register before its first frame appears. Requests may come back to back: a
// five-stage binary-to-decimal pipeline holds up to five of them while the
// frame serialiser works; the serialiser, emitting one frame per cycle, loads
// the next request only on the final frame of the last. busy rises only when
// every stage is full and the serialiser is active and not on its final frame.
module seven_segment_decimal_frame_formatter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ssdff_pkg::request_t request,
	output logic                strobe,
	output ssdff_pkg::frame_t   frame
);

	ssdff_pkg::conv_t cv_s1, cv_s2, cv_s3, cv_s4, cv_s5;
	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic             ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;
	ssdff_pkg::conv_t nx_s1, nx_s2, nx_s3, nx_s4, nx_s5;

	logic [1:0]  em_func_q;
	logic        em_chip_q;
	logic        em_base_q;
	logic        em_ovf_q;
	logic [31:0] em_bcd_q;
	logic [2:0]  em_pos_q;
	logic        em_seen_q;
	logic        em_act_q;
	logic        em_free;

	logic              strobe_q;
	ssdff_pkg::frame_t frame_q;

	logic [3:0]        cur_digit;
	logic [7:0]        cur_code;
	logic [3:0]        cur_addr;
	ssdff_pkg::frame_t cur_frame;
	logic              accept;

	assign em_free = !em_act_q || (em_pos_q == 3'd0);
	assign ld_s5   = !vld_s5 || em_free;
	assign ld_s4   = !vld_s4 || ld_s5;
	assign ld_s3   = !vld_s3 || ld_s4;
	assign ld_s2   = !vld_s2 || ld_s3;
	assign ld_s1   = !vld_s1 || ld_s2;
	assign busy    = !ld_s1;
	assign accept  = start && !busy;

	// stage 1: overflow check and load of the binary operand
	always_comb begin
		logic [31:0] lim;
		unique case (request.func)
			ssdff_pkg::FUNC_DEC8: lim = ssdff_pkg::LIMIT_DEC8;
			ssdff_pkg::FUNC_DEC4: lim = ssdff_pkg::LIMIT_DEC4;
			ssdff_pkg::FUNC_DUTY: lim = ssdff_pkg::LIMIT_DUTY;
			default:              lim = 32'hFFFF_FFFF;
		endcase
		nx_s1.func       = request.func;
		nx_s1.chip_index = request.chip_index;
		nx_s1.half       = request.half;
		nx_s1.ovf        = (request.func != ssdff_pkg::FUNC_DASH) && (request.value > lim);
		nx_s1.dd         = {{ssdff_pkg::BCD_W{1'b0}}, request.value[ssdff_pkg::BIN_W-1:0]};
	end

	// stages 2..5: shift-and-add-three, 7 + 7 + 7 + 6 steps
	always_comb begin
		nx_s2 = cv_s1;
		for (int i = 0; i < ssdff_pkg::STEPS_A; i++) nx_s2.dd = ssdff_pkg::dd_step(nx_s2.dd);
		nx_s3 = cv_s2;
		for (int i = 0; i < ssdff_pkg::STEPS_A; i++) nx_s3.dd = ssdff_pkg::dd_step(nx_s3.dd);
		nx_s4 = cv_s3;
		for (int i = 0; i < ssdff_pkg::STEPS_A; i++) nx_s4.dd = ssdff_pkg::dd_step(nx_s4.dd);
		nx_s5 = cv_s4;
		for (int i = 0; i < ssdff_pkg::STEPS_B; i++) nx_s5.dd = ssdff_pkg::dd_step(nx_s5.dd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (ld_s1) vld_s1 <= accept;
			if (ld_s2) vld_s2 <= vld_s1;
			if (ld_s3) vld_s3 <= vld_s2;
			if (ld_s4) vld_s4 <= vld_s3;
			if (ld_s5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) cv_s1 <= nx_s1;
		if (ld_s2) cv_s2 <= nx_s2;
		if (ld_s3) cv_s3 <= nx_s3;
		if (ld_s4) cv_s4 <= nx_s4;
		if (ld_s5) cv_s5 <= nx_s5;
	end

	// frame serialiser
	assign cur_digit = em_bcd_q[{em_pos_q, 2'b00} +: 4];

	always_comb begin
		priority if (em_func_q == ssdff_pkg::FUNC_DASH) begin
			cur_code = ssdff_pkg::CODE_DASH;
		end else if (em_func_q == ssdff_pkg::FUNC_DUTY && em_pos_q == ssdff_pkg::POS_HALF) begin
			cur_code = ssdff_pkg::CODE_D;
		end else if (em_ovf_q) begin
			cur_code = ssdff_pkg::CODE_OVF;
		end else if (!em_seen_q && cur_digit == 4'd0 && em_pos_q != 3'd0) begin
			cur_code = ssdff_pkg::CODE_OFF;
		end else begin
			cur_code = ssdff_pkg::seg_of(cur_digit);
		end
		cur_addr = {1'b0, em_base_q, 2'b00} + {1'b0, em_pos_q} + 4'd1;
		if (em_chip_q) begin
			cur_frame.lead_addr  = cur_addr;
			cur_frame.lead_data  = cur_code;
			cur_frame.trail_addr = 4'd0;
			cur_frame.trail_data = 8'd0;
		end else begin
			cur_frame.lead_addr  = 4'd0;
			cur_frame.lead_data  = 8'd0;
			cur_frame.trail_addr = cur_addr;
			cur_frame.trail_data = cur_code;
		end
		cur_frame.last = (em_pos_q == 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_act_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= em_act_q;
			if (em_free) em_act_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		frame_q <= cur_frame;
		if (em_free) begin
			em_func_q <= cv_s5.func;
			em_chip_q <= cv_s5.chip_index;
			em_base_q <= cv_s5.half && (cv_s5.func != ssdff_pkg::FUNC_DEC8);
			em_ovf_q  <= cv_s5.ovf;
			em_bcd_q  <= cv_s5.dd[ssdff_pkg::DD_W-1:ssdff_pkg::BIN_W];
			em_pos_q  <= (cv_s5.func == ssdff_pkg::FUNC_DEC8) ? ssdff_pkg::POS_DEC8
			                                                  : ssdff_pkg::POS_HALF;
			em_seen_q <= 1'b0;
		end else begin
			em_pos_q  <= em_pos_q - 3'd1;
			em_seen_q <= em_seen_q || (cur_digit != 4'd0);
		end
	end

	assign strobe = strobe_q;
	assign frame  = frame_q;

endmodule

// ----- hdl/ssdff_chk.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame formatter checker
// Port-level properties of the frame stream, bound to the top level.
// ----------------------------------------------------------------------------
module ssdff_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                strobe,
	input ssdff_pkg::frame_t   frame
);

	logic [3:0] dig_addr;
	assign dig_addr = frame.lead_addr | frame.trail_addr;

	// one pair of every frame is the no-op
	a_noop_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (frame.lead_addr == 4'd0 && frame.lead_data == 8'd0) ||
		           (frame.trail_addr == 4'd0 && frame.trail_data == 8'd0))
		else $error("frame without a no-op pair");

	// digit register address within 1..8
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (dig_addr >= 4'd1 && dig_addr <= 4'd8))
		else $error("digit address out of range");

	// frames of a transaction come on consecutive cycles
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !frame.last |=> strobe)
		else $error("gap inside a transaction");

	// digits are written from the top position down
	a_descend: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !frame.last |=> dig_addr == $past(dig_addr) - 4'd1)
		else $error("digit address not descending");

	// the final frame always writes the lowest digit of its half
	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame.last |-> (dig_addr == 4'd1 || dig_addr == 4'd5))
		else $error("final frame on wrong digit");

endmodule

bind seven_segment_decimal_frame_formatter ssdff_chk u_ssdff_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.strobe  (strobe),
	.frame   (frame)
);

// ----- verif/frame_checker.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame formatter checker
// Watches the request and frame channels. Works out the frames each accepted
// request must produce, then compares every strobed frame against the oldest
// outstanding one and counts the failures.
// ----------------------------------------------------------------------------
module frame_checker
	import ssdff_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  request_t request,
	input  logic     strobe,
	input  frame_t   frame,
	output int       fail_count,
	output int       frames_pending,
	output int       frames_checked
);

	// segment patterns for digits 9..0, digit d at bits 8*d +: 8
	localparam logic [79:0] DIGIT_SEGMENTS = {
		8'h7b, 8'h7f, 8'h70, 8'h5f, 8'h5b, 8'h33, 8'h79, 8'h6d, 8'h30, 8'h7e
	};

	frame_t frames_due [$];
	int     failures = 0;
	int     checked = 0;
	int     pending = 0;

	assign fail_count     = failures;
	assign frames_pending = pending;
	assign frames_checked = checked;

	function automatic void push_frame(input logic digit_leads, input logic [3:0] addr,
		input logic [7:0] data, input logic is_last);
		frame_t f;
		f = '0;
		if (digit_leads) begin
			f.lead_addr = addr;
			f.lead_data = data;
		end else begin
			f.trail_addr = addr;
			f.trail_data = data;
		end
		f.last = is_last;
		frames_due.push_back(f);
	endfunction

	// digits ndig-1 down to 0; the ones digit always closes the transaction
	function automatic void push_digits(input logic digit_leads, input logic [3:0] base,
		input int ndig, input logic [31:0] v, input logic [31:0] limit);
		logic [7:0]  code;
		logic [31:0] scale;
		logic [31:0] digit;
		for (int p = ndig - 1; p >= 0; p--) begin
			scale = 32'd1;
			for (int i = 0; i < p; i++) begin
				scale = scale * 32'd10;
			end
			digit = (v / scale) % 32'd10;
			if (v > limit) begin
				code = CODE_OVF;
			end else if (p > 0 && v < scale) begin
				code = CODE_OFF;
			end else begin
				code = DIGIT_SEGMENTS[8*digit +: 8];
			end
			push_frame(digit_leads, base + 4'(p + 1), code, p == 0);
		end
	endfunction

	function automatic void format_request(input request_t rq);
		logic [3:0] base;
		base = rq.half ? 4'd4 : 4'd0;
		case (rq.func)
			FUNC_DEC8: begin
				push_digits(rq.chip_index, 4'd0, 8, rq.value, LIMIT_DEC8);
			end
			FUNC_DEC4: begin
				push_digits(rq.chip_index, base, 4, rq.value, LIMIT_DEC4);
			end
			FUNC_DUTY: begin
				push_frame(rq.chip_index, base + 4'd4, CODE_D, 1'b0);
				push_digits(rq.chip_index, base, 3, rq.value, LIMIT_DUTY);
			end
			default: begin
				for (int p = 3; p >= 0; p--) begin
					push_frame(rq.chip_index, base + 4'(p + 1), CODE_DASH, p == 0);
				end
			end
		endcase
	endfunction

	function automatic int check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin
		frame_t want;
		if (arst_n) begin
			if (strobe) begin
				if (frames_due.size() == 0) begin
					$error("frame %h strobed with no transaction outstanding", frame);
					failures = failures + 1;
				end else begin
					want = frames_due.pop_front();
					failures = failures
						+ check_field("lead_addr", 8'(want.lead_addr), 8'(frame.lead_addr))
						+ check_field("lead_data", want.lead_data, frame.lead_data)
						+ check_field("trail_addr", 8'(want.trail_addr), 8'(frame.trail_addr))
						+ check_field("trail_data", want.trail_data, frame.trail_data)
						+ check_field("last", 8'(want.last), 8'(frame.last));
					checked = checked + 1;
				end
			end
			if (start && !busy) begin
				format_request(request);
			end
			pending <= frames_due.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame formatter testbench
// Drives directed corner-case requests for every display mode, then random
// requests with random idle gaps, while the checker compares each frame.
// ----------------------------------------------------------------------------
module tb;
	import ssdff_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     strobe;
	frame_t   frame;
	int       fail_count;
	int       frames_pending;
	int       frames_checked;
	int       sent_per_func [4] = '{default: 0};

	seven_segment_decimal_frame_formatter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.strobe  (strobe),
		.frame   (frame)
	);

	frame_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.strobe         (strobe),
		.frame          (frame),
		.fail_count     (fail_count),
		.frames_pending (frames_pending),
		.frames_checked (frames_checked)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic request_t random_request();
		request_t    rq;
		logic [31:0] scale;
		scale = 32'd1;
		rq.func       = 2'($urandom_range(0, 3));
		rq.chip_index = 1'($urandom_range(0, 1));
		rq.half       = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				repeat ($urandom_range(1, 9)) scale = scale * 32'd10;
				rq.value = $urandom % scale;
			end
			5: begin
				rq.value = $urandom;
			end
			6: begin
				repeat ($urandom_range(1, 9)) scale = scale * 32'd10;
				rq.value = scale - 32'($urandom_range(0, 1));
			end
			7: begin
				case ($urandom_range(0, 2))
					0:       rq.value = LIMIT_DEC8;
					1:       rq.value = LIMIT_DEC4;
					default: rq.value = LIMIT_DUTY;
				endcase
				rq.value = rq.value + 32'($urandom_range(0, 2)) - 32'd1;
			end
			default: begin
				rq.value = $urandom_range(0, 120);
			end
		endcase
		return rq;
	endfunction

	// hold start until the transaction is taken; a zero gap keeps start high
	task automatic send_request(input request_t rq, input int gap);
		request <= rq;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent_per_func[rq.func]++;
		if (gap > 0) begin
			start <= 1'b0;
			request <= random_request();
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic directed_request(input logic [1:0] func, input logic chip_index,
		input logic half, input logic [31:0] value);
		request_t rq;
		rq.func       = func;
		rq.chip_index = chip_index;
		rq.half       = half;
		rq.value      = value;
		send_request(rq, pick_gap());
	endtask

	initial begin
		logic burst;
		burst = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_request(FUNC_DEC8, 1'b0, 1'b0, 32'd0);
		directed_request(FUNC_DEC8, 1'b1, 1'b1, 32'd1);
		directed_request(FUNC_DEC8, 1'b0, 1'b0, 32'd99999999);
		directed_request(FUNC_DEC8, 1'b1, 1'b0, 32'd100000000);
		directed_request(FUNC_DEC8, 1'b0, 1'b1, 32'hFFFF_FFFF);
		directed_request(FUNC_DEC8, 1'b1, 1'b0, 32'd12345678);
		directed_request(FUNC_DEC8, 1'b0, 1'b1, 32'd10000000);
		directed_request(FUNC_DEC8, 1'b1, 1'b1, 32'd9999999);
		directed_request(FUNC_DEC4, 1'b0, 1'b0, 32'd0);
		directed_request(FUNC_DEC4, 1'b1, 1'b1, 32'd9999);
		directed_request(FUNC_DEC4, 1'b0, 1'b1, 32'd10000);
		directed_request(FUNC_DEC4, 1'b1, 1'b0, 32'd1000);
		directed_request(FUNC_DEC4, 1'b0, 1'b1, 32'd999);
		directed_request(FUNC_DEC4, 1'b1, 1'b0, 32'hFFFF_FFFF);
		directed_request(FUNC_DUTY, 1'b0, 1'b0, 32'd0);
		directed_request(FUNC_DUTY, 1'b1, 1'b1, 32'd100);
		directed_request(FUNC_DUTY, 1'b0, 1'b1, 32'd101);
		directed_request(FUNC_DUTY, 1'b1, 1'b0, 32'd99);
		directed_request(FUNC_DUTY, 1'b0, 1'b0, 32'd10);
		directed_request(FUNC_DUTY, 1'b1, 1'b1, 32'hFFFF_FFFF);
		directed_request(FUNC_DASH, 1'b0, 1'b0, 32'h5A5A_5A5A);
		directed_request(FUNC_DASH, 1'b1, 1'b1, 32'hFFFF_FFFF);
		directed_request(FUNC_DASH, 1'b0, 1'b1, 32'd0);

		for (int k = 0; k < 247; k++) begin
			if (k % 30 == 0) begin
				burst = ($urandom_range(0, 3) == 0);
			end
			send_request(random_request(), burst ? 0 : pick_gap());
		end
		start <= 1'b0;

		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d eight-digit, %0d four-digit, %0d duty-cycle and %0d dash requests",
			sent_per_func[FUNC_DEC8], sent_per_func[FUNC_DEC4],
			sent_per_func[FUNC_DUTY], sent_per_func[FUNC_DASH]);
		$display("Compared %0d frames, %0d failures", frames_checked, fail_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/ssdff_pkg.sv
hdl/seven_segment_decimal_frame_formatter.sv
hdl/ssdff_chk.sv
verif/frame_checker.sv
verif/tb.sv
